[sv/bfrs_pkg.sv]
// ---------------------------------------------------------------------------
// bfrs_pkg
// Shared constants, types and the control store of the fill rate servo.
// ---------------------------------------------------------------------------
package bfrs_pkg;

   localparam int WINDOW     = 100;
   localparam int FILL_W     = 24;
   localparam int RATE_W     = 18;
   localparam int SPAN_W     = 16;
   localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W      = FILL_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
   localparam int PROD_W     = SUM_W + SPAN_W;
   localparam int CNT_W      = $clog2(PROD_W + 1);
   localparam int RES_W      = PROD_W + 2;

   localparam int RATE_MIN   = 100;
   localparam int RATE_MAX   = 200000;
   localparam int RATE_RESET = 44100;
   localparam int FILL_RESET = 32768;
   localparam int SPAN_RESET = 300;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_ENABLE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IDEAL_RATE     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_IDEAL_FILL     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_SPAN      = CSR_IDX_W'(3);

   typedef struct packed {
      logic              control_enable;
      logic [RATE_W-1:0] ideal_rate;
      logic [FILL_W-1:0] ideal_fill;
      logic [SPAN_W-1:0] rate_span;
   } cfg_type;

   typedef enum logic [3:0] {
      STEP_WAIT,
      STEP_READ,
      STEP_UPDATE,
      STEP_TARGET,
      STEP_MAG,
      STEP_MUL,
      STEP_DIV_INIT,
      STEP_DIV,
      STEP_FINISH,
      STEP_OUTPUT,
      STEP_END
   } step_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_UPDATE,
      OP_TARGET,
      OP_MAG,
      OP_MUL,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_FINISH,
      OP_OUTPUT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_NO_EN,
      COND_NO_SEC,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic enable;
      logic second;
      logic div_more;
      logic out_busy;
   } seq_status_type;

   // control store: jump to target when the condition holds, else fall through
   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type cw;
      cw = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_WAIT};
      unique case (step)
         STEP_WAIT:     cw = '{op: OP_CAPTURE,  cond: COND_NO_REQ,   target: STEP_WAIT};
         STEP_READ:     cw = '{op: OP_NONE,     cond: COND_NO_EN,    target: STEP_OUTPUT};
         STEP_UPDATE:   cw = '{op: OP_UPDATE,   cond: COND_NO_SEC,   target: STEP_OUTPUT};
         STEP_TARGET:   cw = '{op: OP_TARGET,   cond: COND_NEXT,     target: STEP_WAIT};
         STEP_MAG:      cw = '{op: OP_MAG,      cond: COND_NEXT,     target: STEP_WAIT};
         STEP_MUL:      cw = '{op: OP_MUL,      cond: COND_NEXT,     target: STEP_WAIT};
         STEP_DIV_INIT: cw = '{op: OP_DIV_INIT, cond: COND_NEXT,     target: STEP_WAIT};
         STEP_DIV:      cw = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: STEP_DIV};
         STEP_FINISH:   cw = '{op: OP_FINISH,   cond: COND_NEXT,     target: STEP_WAIT};
         STEP_OUTPUT:   cw = '{op: OP_OUTPUT,   cond: COND_OUT_BUSY, target: STEP_OUTPUT};
         STEP_END:      cw = '{op: OP_NONE,     cond: COND_ALWAYS,   target: STEP_WAIT};
         default:       cw = '{op: OP_NONE,     cond: COND_ALWAYS,   target: STEP_WAIT};
      endcase
      return cw;
   endfunction

endpackage

[sv/bfrs_ram.sv]
// ---------------------------------------------------------------------------
// bfrs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bfrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bfrs_seq.sv]
// ---------------------------------------------------------------------------
// bfrs_seq
// Step counter and control store; evaluates the jump condition each cycle.
// ---------------------------------------------------------------------------
module bfrs_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bfrs_pkg::seq_status_type status,
   output bfrs_pkg::op_type        op
);
   import bfrs_pkg::*;

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type cw;
   logic          jump;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      cw = ucode(step_ff);
      unique case (cw.cond)
         COND_NEXT:     jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !req_valid;
         COND_NO_EN:    jump = !status.enable;
         COND_NO_SEC:   jump = !status.second;
         COND_DIV_MORE: jump = status.div_more;
         COND_OUT_BUSY: jump = status.out_busy;
         default:       jump = 1'b1;
      endcase
      step_in   = jump ? cw.target : step_type'(step_ff + 4'd1);
      op        = cw.op;
      req_stall = (step_ff != STEP_WAIT);
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_END)
      else $error("step counter left the program");

   a_accept_capture: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (op == OP_CAPTURE))
      else $error("transfer accepted outside the capture step");

endmodule

[sv/bfrs_dp.sv]
// ---------------------------------------------------------------------------
// bfrs_dp
// Datapath: window history and running sum, target and error magnitude,
// multiplier, bit-serial restoring divider, saturation and result register.
// ---------------------------------------------------------------------------
module bfrs_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  bfrs_pkg::op_type             op,
   input  bfrs_pkg::cfg_type            cfg,
   input  logic                         req_valid,
   input  logic [bfrs_pkg::FILL_W-1:0]  req_fill_level,
   input  logic                         req_second_elapsed,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bfrs_pkg::RATE_W-1:0]  rsp_play_rate,
   output logic                         rsp_rate_updated,
   output bfrs_pkg::seq_status_type     status
);
   import bfrs_pkg::*;

   logic [FILL_W-1:0] level_ff, level_in;
   logic              second_ff, second_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              full_ff, full_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  tgt_ff, tgt_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  mag_ff, mag_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              updated_ff, updated_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0] rsp_rate_ff, rsp_rate_in;
   logic              rsp_upd_ff, rsp_upd_in;

   logic [FILL_W-1:0]      ram_rd_data;
   logic [FILL_W-1:0]      old_level;
   logic [FILL_W-1:0]      fill_nz;
   logic [SUM_W:0]         trial;
   logic [SUM_W:0]         diff;
   logic signed [RES_W-1:0] res;
   logic                   out_busy;

   bfrs_ram #(
      .WIDTH(FILL_W),
      .DEPTH(WINDOW)
   ) u_history (
      .clock  (clock),
      .wr_en  (op == OP_UPDATE),
      .wr_addr(idx_ff),
      .wr_data(level_ff),
      .rd_addr(idx_ff),
      .rd_data(ram_rd_data)
   );

   assign out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      level_in     = level_ff;
      second_in    = second_ff;
      idx_in       = idx_ff;
      full_in      = full_ff;
      sum_in       = sum_ff;
      tgt_in       = tgt_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rate_in      = rate_ff;
      updated_in   = updated_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_upd_in   = rsp_upd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // slots not yet written since reset count as zero
      old_level = full_ff ? ram_rd_data : '0;
      fill_nz   = (cfg.ideal_fill == '0) ? FILL_W'(1) : cfg.ideal_fill;
      trial     = {rem_ff, quo_ff[PROD_W-1]};
      diff      = trial - {1'b0, tgt_ff};
      res       = neg_ff ? $signed(RES_W'(cfg.ideal_rate)) - $signed(RES_W'(quo_ff))
                         : $signed(RES_W'(cfg.ideal_rate)) + $signed(RES_W'(quo_ff));

      case (op)
         OP_CAPTURE: begin
            if (req_valid) begin
               level_in   = req_fill_level;
               second_in  = req_second_elapsed;
               updated_in = 1'b0;
            end
         end
         OP_UPDATE: begin
            sum_in = sum_ff - SUM_W'(old_level) + SUM_W'(level_ff);
            if (idx_ff == IDX_W'(WINDOW - 1)) begin
               idx_in  = '0;
               full_in = 1'b1;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         OP_TARGET: begin
            tgt_in = SUM_W'(fill_nz) * SUM_W'(WINDOW);
         end
         OP_MAG: begin
            neg_in = sum_ff < tgt_ff;
            mag_in = (sum_ff < tgt_ff) ? tgt_ff - sum_ff : sum_ff - tgt_ff;
         end
         OP_MUL: begin
            quo_in = PROD_W'(mag_ff) * PROD_W'(cfg.rate_span);
         end
         OP_DIV_INIT: begin
            rem_in = '0;
            cnt_in = CNT_W'(PROD_W);
         end
         OP_DIV_STEP: begin
            if (!diff[SUM_W]) begin
               rem_in = diff[SUM_W-1:0];
               quo_in = {quo_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[SUM_W-1:0];
               quo_in = {quo_ff[PROD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
         OP_FINISH: begin
            if (res < $signed(RES_W'(RATE_MIN))) begin
               rate_in = RATE_W'(RATE_MIN);
            end else if (res > $signed(RES_W'(RATE_MAX))) begin
               rate_in = RATE_W'(RATE_MAX);
            end else begin
               rate_in = res[RATE_W-1:0];
            end
            updated_in = 1'b1;
         end
         OP_OUTPUT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = rate_ff;
               rsp_upd_in   = updated_ff;
            end
         end
         default: begin
         end
      endcase

      status.enable   = cfg.control_enable;
      status.second   = second_ff;
      status.div_more = (cnt_ff != CNT_W'(1));
      status.out_busy = out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         rate_ff      <= RATE_W'(RATE_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         full_ff      <= full_in;
         sum_ff       <= sum_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_ff    <= level_in;
      second_ff   <= second_in;
      tgt_ff      <= tgt_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      updated_ff  <= updated_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_upd_ff  <= rsp_upd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_play_rate    = rsp_rate_ff;
   assign rsp_rate_updated = rsp_upd_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (op == OP_DIV_STEP) |-> (rem_ff < tgt_ff))
      else $error("divider remainder not below divisor");

   a_rate_in_range: assert property (@(posedge clock) disable iff (reset)
      (rate_ff >= RATE_W'(RATE_MIN)) && (rate_ff <= RATE_W'(RATE_MAX)))
      else $error("current rate outside saturation range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && (op != OP_OUTPUT)) |=> $stable(rsp_rate_ff))
      else $error("pending result overwritten");

endmodule

[sv/buffer_fill_rate_servo_core.sv]
// ---------------------------------------------------------------------------
// buffer_fill_rate_servo_core
// Playback rate servo driven by a windowed average of buffer fill levels.
// ---------------------------------------------------------------------------
// One transfer in gives one transfer out. With control disabled, or enabled
// with no new second, an item skips the rate computation; an item that
// recomputes the rate runs the bit-serial restoring divider (one quotient bit
// per cycle over the 47-bit product) in the microcoded sequence. The result
// sits in an output register, so the next item is taken while a result waits.
// The fill history lives in a RAM tracked by a fill flag, so no clearing pass
// follows reset. Configuration must be written through the csr_ port only
// while no item is in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module buffer_fill_rate_servo_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bfrs_pkg::FILL_W-1:0]     req_fill_level,
   input  logic                            req_second_elapsed,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bfrs_pkg::RATE_W-1:0]     rsp_play_rate,
   output logic                            rsp_rate_updated,
   input  logic                            csr_write_enable,
   input  logic [bfrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfrs_pkg::CSR_DATA_W-1:0] csr_data
);
   import bfrs_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   op_type         op;
   seq_status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CONTROL_ENABLE: cfg_in.control_enable = csr_data[0];
            CSR_IDEAL_RATE:     cfg_in.ideal_rate     = csr_data[RATE_W-1:0];
            CSR_IDEAL_FILL:     cfg_in.ideal_fill     = csr_data[FILL_W-1:0];
            CSR_RATE_SPAN:      cfg_in.rate_span      = csr_data[SPAN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control_enable <= 1'b0;
         cfg_ff.ideal_rate     <= RATE_W'(RATE_RESET);
         cfg_ff.ideal_fill     <= FILL_W'(FILL_RESET);
         cfg_ff.rate_span      <= SPAN_W'(SPAN_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bfrs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .op       (op)
   );

   bfrs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_fill_level    (req_fill_level),
      .req_second_elapsed(req_second_elapsed),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_play_rate     (rsp_play_rate),
      .rsp_rate_updated  (rsp_rate_updated),
      .status            (status)
   );

endmodule
